>>> src/uart_rb_pkg.sv
// uart_rb_pkg: shared types and constants of the uart register block
// register offsets, status bit positions, operation codes and result word
// no dependencies
package uart_rb_pkg;

	// payload widths
	localparam int unsigned OP_W     = 2;
	localparam int unsigned OFFSET_W = 10;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned BYTE_W   = 8;

	// default queue depth for both byte queues
	localparam int unsigned DEF_QUEUE_DEPTH = 16;

	// register byte offsets within the peripheral window
	localparam logic [OFFSET_W-1:0] OFF_STATUS = 10'h000;
	localparam logic [OFFSET_W-1:0] OFF_DATA   = 10'h004;
	localparam logic [OFFSET_W-1:0] OFF_BAUD   = 10'h008;
	localparam logic [OFFSET_W-1:0] OFF_CTL1   = 10'h00C;
	localparam logic [OFFSET_W-1:0] OFF_CTL2   = 10'h010;
	localparam logic [OFFSET_W-1:0] OFF_CTL3   = 10'h014;
	localparam logic [OFFSET_W-1:0] OFF_GUARD  = 10'h018;

	// status register bit positions
	localparam int unsigned BIT_RXNE = 5;
	localparam int unsigned BIT_TC   = 6;
	localparam int unsigned BIT_TXE  = 7;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_READ   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_INJECT = 2'd2,
		OP_POP    = 2'd3
	} op_t;

	// one result word
	typedef struct packed {
		logic [WORD_W-1:0] read_data;
		logic              rx_accepted;
		logic              tx_event;
		logic [BYTE_W-1:0] tx_byte;
		logic              drained_valid;
		logic [BYTE_W-1:0] drained_byte;
	} rsp_t;

endpackage

>>> src/uart_rb_if.sv
// uart_rb_req_if, uart_rb_rsp_if: valid/ready channels of the uart register block
// request channel carries one bus access or queue operation, response one result
// depends on uart_rb_pkg
interface uart_rb_req_if
	import uart_rb_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	logic [OFFSET_W-1:0] reg_offset;
	logic [WORD_W-1:0]   write_value;
	logic [BYTE_W-1:0]   rx_byte;

	modport source (output valid, output operation, output reg_offset,
		output write_value, output rx_byte, input ready);
	modport sink (input valid, input operation, input reg_offset,
		input write_value, input rx_byte, output ready);
endinterface

interface uart_rb_rsp_if
	import uart_rb_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] read_data;
	logic              rx_accepted;
	logic              tx_event;
	logic [BYTE_W-1:0] tx_byte;
	logic              drained_valid;
	logic [BYTE_W-1:0] drained_byte;

	modport source (output valid, output read_data, output rx_accepted,
		output tx_event, output tx_byte, output drained_valid,
		output drained_byte, input ready);
	modport sink (input valid, input read_data, input rx_accepted,
		input tx_event, input tx_byte, input drained_valid,
		input drained_byte, output ready);
endinterface

>>> src/uart_register_block.sv
// uart_register_block: two register stages, the request stage and the result register; one
// word per cycle while the result side does not stall; the request is registered with the queue
// head reads, then the register file and queue pointers update as the result register loads
// asynchronous reset clears status (complete and tx empty set), config words, counts and
// pointers; the queue storage itself is not cleared and holds no meaning until written
// depends on uart_rb_pkg and uart_rb_if
module uart_register_block
	import uart_rb_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	uart_rb_req_if.sink   req,
	uart_rb_rsp_if.source rsp
);

	localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

	// request stage
	logic                s1_valid_q;
	op_t                 op_s1;
	logic [OFFSET_W-1:0] off_s1;
	logic [WORD_W-1:0]   val_s1;
	logic [BYTE_W-1:0]   rxb_s1;
	logic [BYTE_W-1:0]   rx_head_s1;
	logic [BYTE_W-1:0]   tx_head_s1;

	// result register
	logic out_valid_q;
	rsp_t out_q;

	// register file
	logic              tc_q;
	logic              txe_q;
	logic [WORD_W-1:0] baud_q;
	logic [WORD_W-1:0] ctl1_q;
	logic [WORD_W-1:0] ctl2_q;
	logic [WORD_W-1:0] ctl3_q;
	logic [WORD_W-1:0] guard_q;

	// queues
	logic [BYTE_W-1:0] rx_mem [QUEUE_DEPTH];
	logic [BYTE_W-1:0] tx_mem [QUEUE_DEPTH];
	logic [CW-1:0]     rx_count_q;
	logic [CW-1:0]     tx_count_q;
	logic [AW-1:0]     rx_head_q;
	logic [AW-1:0]     rx_tail_q;
	logic [AW-1:0]     tx_head_q;
	logic [AW-1:0]     tx_tail_q;

	// combinational controls
	logic              do_s1;
	logic              accept;
	logic              rx_push;
	logic              rx_pop;
	logic              tx_push;
	logic              tx_pop;
	logic              tc_wr;
	logic              tc_val;
	logic              txe_set;
	logic              baud_wr;
	logic              ctl1_wr;
	logic              ctl2_wr;
	logic              ctl3_wr;
	logic              guard_wr;
	rsp_t              res;
	logic [AW-1:0]     rx_head_inc;
	logic [AW-1:0]     rx_tail_inc;
	logic [AW-1:0]     tx_head_inc;
	logic [AW-1:0]     tx_tail_inc;
	logic [AW-1:0]     rx_rd_addr;
	logic [AW-1:0]     tx_rd_addr;

	// handshake
	assign do_s1     = s1_valid_q && (!out_valid_q || rsp.ready);
	assign req.ready = !s1_valid_q || do_s1;
	assign accept    = req.valid && req.ready;

	// pointer increments with wrap at any depth
	assign rx_head_inc = (rx_head_q == LAST_IDX) ? '0 : rx_head_q + AW'(1);
	assign rx_tail_inc = (rx_tail_q == LAST_IDX) ? '0 : rx_tail_q + AW'(1);
	assign tx_head_inc = (tx_head_q == LAST_IDX) ? '0 : tx_head_q + AW'(1);
	assign tx_tail_inc = (tx_tail_q == LAST_IDX) ? '0 : tx_tail_q + AW'(1);

	// head each queue will have once the stage item retires
	assign rx_rd_addr = (do_s1 && rx_pop) ? rx_head_inc : rx_head_q;
	assign tx_rd_addr = (do_s1 && tx_pop) ? tx_head_inc : tx_head_q;

	// decode of the staged item and result word
	always_comb begin
		logic [WORD_W-1:0] status_word;
		logic              rx_empty;
		logic              rx_full;
		logic              tx_empty;
		logic              tx_full;
		rx_empty = (rx_count_q == '0);
		rx_full  = (rx_count_q == FULL_CNT);
		tx_empty = (tx_count_q == '0);
		tx_full  = (tx_count_q == FULL_CNT);
		// receive-not-empty always reflects the receive count when read
		status_word           = '0;
		status_word[BIT_RXNE] = !rx_empty;
		status_word[BIT_TC]   = tc_q;
		status_word[BIT_TXE]  = txe_q;
		rx_push  = 1'b0;
		rx_pop   = 1'b0;
		tx_push  = 1'b0;
		tx_pop   = 1'b0;
		tc_wr    = 1'b0;
		tc_val   = tc_q;
		txe_set  = 1'b0;
		baud_wr  = 1'b0;
		ctl1_wr  = 1'b0;
		ctl2_wr  = 1'b0;
		ctl3_wr  = 1'b0;
		guard_wr = 1'b0;
		res      = '0;
		case (op_s1)
			OP_READ: begin
				case (off_s1)
					OFF_STATUS: res.read_data = status_word;
					OFF_DATA: begin
						if (!rx_empty) begin
							rx_pop        = 1'b1;
							res.read_data = WORD_W'(rx_head_s1);
						end
					end
					OFF_BAUD:  res.read_data = baud_q;
					OFF_CTL1:  res.read_data = ctl1_q;
					OFF_CTL2:  res.read_data = ctl2_q;
					OFF_CTL3:  res.read_data = ctl3_q;
					OFF_GUARD: res.read_data = guard_q;
					default:   res.read_data = '0;
				endcase
			end
			OP_WRITE: begin
				case (off_s1)
					OFF_DATA: begin
						// byte is dropped on a full queue but the event still goes out
						tx_push      = !tx_full;
						tc_wr        = 1'b1;
						tc_val       = 1'b1;
						txe_set      = 1'b1;
						res.tx_event = 1'b1;
						res.tx_byte  = val_s1[BYTE_W-1:0];
					end
					OFF_STATUS: begin
						tc_wr  = 1'b1;
						tc_val = val_s1[BIT_TC];
					end
					OFF_BAUD:  baud_wr  = 1'b1;
					OFF_CTL1:  ctl1_wr  = 1'b1;
					OFF_CTL2:  ctl2_wr  = 1'b1;
					OFF_CTL3:  ctl3_wr  = 1'b1;
					OFF_GUARD: guard_wr = 1'b1;
					default:   tc_wr    = 1'b0;
				endcase
			end
			OP_INJECT: begin
				rx_push         = !rx_full;
				res.rx_accepted = !rx_full;
			end
			OP_POP: begin
				if (!tx_empty) begin
					tx_pop            = 1'b1;
					res.drained_valid = 1'b1;
					res.drained_byte  = tx_head_s1;
				end
			end
			default: res = '0;
		endcase
	end

	// request stage and head read, written entry forwarded when it becomes the head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req.ready) begin
			s1_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= op_t'(req.operation);
			off_s1 <= req.reg_offset;
			val_s1 <= req.write_value;
			rxb_s1 <= req.rx_byte;
			if (do_s1 && rx_push && rx_tail_q == rx_rd_addr) begin
				rx_head_s1 <= rxb_s1;
			end else begin
				rx_head_s1 <= rx_mem[rx_rd_addr];
			end
			if (do_s1 && tx_push && tx_tail_q == tx_rd_addr) begin
				tx_head_s1 <= val_s1[BYTE_W-1:0];
			end else begin
				tx_head_s1 <= tx_mem[tx_rd_addr];
			end
		end
	end

	// queue storage writes
	always_ff @(posedge clk) begin
		if (do_s1 && rx_push) begin
			rx_mem[rx_tail_q] <= rxb_s1;
		end
		if (do_s1 && tx_push) begin
			tx_mem[tx_tail_q] <= val_s1[BYTE_W-1:0];
		end
	end

	// queue pointers and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_count_q <= '0;
			rx_head_q  <= '0;
			rx_tail_q  <= '0;
			tx_count_q <= '0;
			tx_head_q  <= '0;
			tx_tail_q  <= '0;
		end else if (do_s1) begin
			if (rx_push) begin
				rx_tail_q  <= rx_tail_inc;
				rx_count_q <= rx_count_q + CW'(1);
			end
			if (rx_pop) begin
				rx_head_q  <= rx_head_inc;
				rx_count_q <= rx_count_q - CW'(1);
			end
			if (tx_push) begin
				tx_tail_q  <= tx_tail_inc;
				tx_count_q <= tx_count_q + CW'(1);
			end
			if (tx_pop) begin
				tx_head_q  <= tx_head_inc;
				tx_count_q <= tx_count_q - CW'(1);
			end
		end
	end

	// status and configuration words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q    <= 1'b1;
			txe_q   <= 1'b1;
			baud_q  <= '0;
			ctl1_q  <= '0;
			ctl2_q  <= '0;
			ctl3_q  <= '0;
			guard_q <= '0;
		end else if (do_s1) begin
			if (tc_wr)    tc_q    <= tc_val;
			if (txe_set)  txe_q   <= 1'b1;
			if (baud_wr)  baud_q  <= val_s1;
			if (ctl1_wr)  ctl1_q  <= val_s1;
			if (ctl2_wr)  ctl2_q  <= val_s1;
			if (ctl3_wr)  ctl3_q  <= val_s1;
			if (guard_wr) guard_q <= val_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_s1) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_s1) begin
			out_q <= res;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.read_data     = out_q.read_data;
	assign rsp.rx_accepted   = out_q.rx_accepted;
	assign rsp.tx_event      = out_q.tx_event;
	assign rsp.tx_byte       = out_q.tx_byte;
	assign rsp.drained_valid = out_q.drained_valid;
	assign rsp.drained_byte  = out_q.drained_byte;

	// counts stay within the queue depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rx_count_q <= FULL_CNT && tx_count_q <= FULL_CNT)
		else $error("queue count beyond depth");

	// pointers meet only when a queue is empty or full
	a_rx_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_head_q == rx_tail_q) |-> (rx_count_q == '0 || rx_count_q == FULL_CNT))
		else $error("rx pointers disagree with count");

	a_tx_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(tx_head_q == tx_tail_q) |-> (tx_count_q == '0 || tx_count_q == FULL_CNT))
		else $error("tx pointers disagree with count");

	// a retiring item always lands in the result register
	a_retire: assert property (@(posedge clk) disable iff (!arst_n)
		do_s1 |=> out_valid_q)
		else $error("retired item lost");

	// queue state only moves when an item retires
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!do_s1 |=> ($stable(rx_count_q) && $stable(tx_count_q)))
		else $error("queue count changed without an item");

endmodule

>>> tb/uart_rb_checker.sv
// uart_rb_checker: watches the request and response channels of the uart register block,
// predicts each result word from its own copy of registers and byte queues, and compares
// depends on uart_rb_pkg and the channel interfaces in uart_rb_if
module uart_rb_checker
	import uart_rb_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	uart_rb_req_if req,
	uart_rb_rsp_if rsp,
	output int     fail_count,
	output int     pending,
	output int     words_in,
	output int     results_out,
	output int     rx_drops,
	output int     tx_drops,
	output int     empty_reads,
	output int     empty_pops
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH = DEF_QUEUE_DEPTH;

	// shadow of the block's registers and queues
	logic [BYTE_W-1:0] flags;
	logic [WORD_W-1:0] baud_q, ctl1_q, ctl2_q, ctl3_q, guard_q;
	logic [BYTE_W-1:0] rx_mem [DEPTH];
	logic [BYTE_W-1:0] tx_mem [DEPTH];
	int unsigned       rx_cnt, rx_hd, tx_cnt, tx_hd;

	rsp_t due_results[$];
	int   errs, reports, n_in, n_out, n_rxd, n_txd, n_er, n_ep;

	// apply one access to the shadow state and return the word it should produce
	function automatic rsp_t apply_access(op_t op, logic [OFFSET_W-1:0] off,
		logic [WORD_W-1:0] val, logic [BYTE_W-1:0] rxb);
		rsp_t r;
		r = '0;
		case (op)
			OP_READ: begin
				case (off)
					OFF_STATUS: begin
						flags[BIT_RXNE] = (rx_cnt != 0);
						r.read_data[BYTE_W-1:0] = flags;
					end
					OFF_DATA: begin
						if (rx_cnt != 0) begin
							r.read_data[BYTE_W-1:0] = rx_mem[rx_hd];
							rx_hd = (rx_hd + 1) % DEPTH;
							rx_cnt--;
						end else begin
							n_er++;
						end
						if (rx_cnt == 0)
							flags[BIT_RXNE] = 1'b0;
					end
					OFF_BAUD:  r.read_data = baud_q;
					OFF_CTL1:  r.read_data = ctl1_q;
					OFF_CTL2:  r.read_data = ctl2_q;
					OFF_CTL3:  r.read_data = ctl3_q;
					OFF_GUARD: r.read_data = guard_q;
					default:   r.read_data = '0;
				endcase
			end
			OP_WRITE: begin
				case (off)
					OFF_DATA: begin
						// full queue drops the byte, event and flags still happen
						if (tx_cnt < DEPTH) begin
							tx_mem[(tx_hd + tx_cnt) % DEPTH] = val[BYTE_W-1:0];
							tx_cnt++;
						end else begin
							n_txd++;
						end
						flags[BIT_TXE] = 1'b1;
						flags[BIT_TC]  = 1'b1;
						r.tx_event = 1'b1;
						r.tx_byte  = val[BYTE_W-1:0];
					end
					OFF_STATUS: flags[BIT_TC] = val[BIT_TC];
					OFF_BAUD:   baud_q  = val;
					OFF_CTL1:   ctl1_q  = val;
					OFF_CTL2:   ctl2_q  = val;
					OFF_CTL3:   ctl3_q  = val;
					OFF_GUARD:  guard_q = val;
					default:    ;
				endcase
			end
			OP_INJECT: begin
				if (rx_cnt < DEPTH) begin
					rx_mem[(rx_hd + rx_cnt) % DEPTH] = rxb;
					rx_cnt++;
					flags[BIT_RXNE] = 1'b1;
					r.rx_accepted = 1'b1;
				end else begin
					n_rxd++;
				end
			end
			default: begin
				if (tx_cnt != 0) begin
					r.drained_valid = 1'b1;
					r.drained_byte  = tx_mem[tx_hd];
					tx_hd = (tx_hd + 1) % DEPTH;
					tx_cnt--;
				end else begin
					n_ep++;
				end
			end
		endcase
		return r;
	endfunction

	// compare results first, then predict the word accepted at this edge
	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_w, got;
		if (!arst_n) begin
			flags = '0;
			flags[BIT_TC]  = 1'b1;
			flags[BIT_TXE] = 1'b1;
			baud_q  = '0;
			ctl1_q  = '0;
			ctl2_q  = '0;
			ctl3_q  = '0;
			guard_q = '0;
			rx_cnt = 0;
			rx_hd  = 0;
			tx_cnt = 0;
			tx_hd  = 0;
			due_results.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.read_data     = rsp.read_data;
				got.rx_accepted   = rsp.rx_accepted;
				got.tx_event      = rsp.tx_event;
				got.tx_byte       = rsp.tx_byte;
				got.drained_valid = rsp.drained_valid;
				got.drained_byte  = rsp.drained_byte;
				n_out++;
				if (due_results.size() == 0) begin
					errs++;
					if (reports < 10) begin
						reports++;
						$display("result %0d arrived with no word outstanding", n_out);
					end
				end else begin
					exp_w = due_results.pop_front();
					if (got.read_data !== exp_w.read_data
						|| got.rx_accepted !== exp_w.rx_accepted
						|| got.tx_event !== exp_w.tx_event
						|| got.tx_byte !== exp_w.tx_byte
						|| got.drained_valid !== exp_w.drained_valid
						|| got.drained_byte !== exp_w.drained_byte) begin
						errs++;
						if (reports < 10) begin
							reports++;
							$display("mismatch on result %0d at %0t", n_out, $realtime);
							$display("  expected rd=%h rxa=%b txe=%b txb=%h dv=%b db=%h",
								exp_w.read_data, exp_w.rx_accepted, exp_w.tx_event,
								exp_w.tx_byte, exp_w.drained_valid, exp_w.drained_byte);
							$display("  actual   rd=%h rxa=%b txe=%b txb=%h dv=%b db=%h",
								got.read_data, got.rx_accepted, got.tx_event,
								got.tx_byte, got.drained_valid, got.drained_byte);
						end
					end
				end
			end
			if (req.valid && req.ready) begin
				n_in++;
				due_results.push_back(apply_access(op_t'(req.operation), req.reg_offset,
					req.write_value, req.rx_byte));
			end
		end
		fail_count  <= errs;
		pending     <= due_results.size();
		words_in    <= n_in;
		results_out <= n_out;
		rx_drops    <= n_rxd;
		tx_drops    <= n_txd;
		empty_reads <= n_er;
		empty_pops  <= n_ep;
	end

endmodule

>>> tb/tb_top.sv
// tb_top: drives bus accesses and line-side queue operations into uart_register_block,
// stalls the result side at random, and reports the verdict from uart_rb_checker
// depends on uart_rb_pkg, uart_rb_if, uart_register_block and uart_rb_checker
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import uart_rb_pkg::*;

	localparam int unsigned DIRECTED_WORDS = 25;
	localparam int unsigned RANDOM_WORDS   = 1250;

	logic clk = 1'b0;
	logic arst_n;
	logic hold_rsp = 1'b0;
	int   sent = 0;
	bit   tx_calm = 1'b0;
	bit   rx_calm = 1'b0;

	int fail_count, pending, words_in, results_out;
	int rx_drops, tx_drops, empty_reads, empty_pops;

	uart_rb_req_if req_ch ();
	uart_rb_rsp_if rsp_ch ();

	uart_register_block dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	uart_rb_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.fail_count  (fail_count),
		.pending     (pending),
		.words_in    (words_in),
		.results_out (results_out),
		.rx_drops    (rx_drops),
		.tx_drops    (tx_drops),
		.empty_reads (empty_reads),
		.empty_pops  (empty_pops)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	initial begin
		#1_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// offer one word after a random gap and wait for its handshake
	task automatic issue(op_t op, logic [OFFSET_W-1:0] off, logic [WORD_W-1:0] val,
		logic [BYTE_W-1:0] rxb);
		int gap;
		if ($urandom_range(0, 39) == 0)
			tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.operation   <= op;
		req_ch.reg_offset  <= off;
		req_ch.write_value <= val;
		req_ch.rx_byte     <= rxb;
		do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
		sent++;
	endtask

	// mostly aligned registers, some unaligned and some anywhere in the window
	function automatic logic [OFFSET_W-1:0] pick_offset();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 7)
			return OFFSET_W'(4 * $urandom_range(0, 6));
		else if (sel < 9)
			return OFFSET_W'($urandom_range(0, 1023));
		else
			return OFFSET_W'(4 * $urandom_range(0, 6) + $urandom_range(1, 3));
	endfunction

	function automatic logic [BYTE_W-1:0] rnd_byte();
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	// result side: random stalls, plus long hold-offs requested by the pressure process
	initial begin
		int gap;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rx_calm = !rx_calm;
			gap = rx_calm ? 0 : $urandom_range(0, 4);
			if (gap != 0 || hold_rsp) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
				while (hold_rsp) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
		end
	end

	// long hold-offs on the result side so the block backs up into its input
	initial begin
		wait (sent >= 300);
		@(posedge clk);
		hold_rsp <= 1'b1;
		repeat (150) @(posedge clk);
		hold_rsp <= 1'b0;
		wait (sent >= 800);
		@(posedge clk);
		hold_rsp <= 1'b1;
		repeat (100) @(posedge clk);
		hold_rsp <= 1'b0;
	end

	// reset, directed words, random words, drain and verdict
	initial begin
		int n;
		int waited;
		arst_n             <= 1'b0;
		req_ch.valid       <= 1'b0;
		req_ch.operation   <= OP_READ;
		req_ch.reg_offset  <= '0;
		req_ch.write_value <= '0;
		req_ch.rx_byte     <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, read of an empty receive queue
		issue(OP_READ, OFF_STATUS, '0, '0);
		issue(OP_READ, OFF_DATA, '0, '0);
		// every plain register written and read back
		issue(OP_WRITE, OFF_BAUD, 32'hFFFF_FFFF, '0);
		issue(OP_WRITE, OFF_CTL1, 32'h0000_0000, '0);
		issue(OP_WRITE, OFF_CTL2, 32'hA5A5_A5A5, '0);
		issue(OP_WRITE, OFF_CTL3, 32'h5A5A_5A5A, '0);
		issue(OP_WRITE, OFF_GUARD, 32'hFFFF_FFFF, '0);
		issue(OP_READ, OFF_BAUD, '0, '0);
		issue(OP_READ, OFF_CTL1, '0, '0);
		issue(OP_READ, OFF_CTL2, '0, '0);
		issue(OP_READ, OFF_CTL3, '0, '0);
		issue(OP_READ, OFF_GUARD, '0, '0);
		// only the complete bit of status takes a write
		issue(OP_WRITE, OFF_STATUS, 32'h0000_0000, '0);
		issue(OP_READ, OFF_STATUS, '0, '0);
		issue(OP_WRITE, OFF_STATUS, 32'hFFFF_FFFF, 8'hFF);
		// unknown offset ignores writes and reads zero
		issue(OP_WRITE, OFFSET_W'(1023), 32'hFFFF_FFFF, '0);
		issue(OP_READ, OFFSET_W'(1023), 32'hFFFF_FFFF, 8'hFF);
		// receive path, not-empty flag set then cleared by the last data read
		issue(OP_INJECT, '0, '0, 8'hFF);
		issue(OP_INJECT, OFFSET_W'(1023), 32'hFFFF_FFFF, 8'h00);
		issue(OP_READ, OFF_STATUS, '0, '0);
		issue(OP_READ, OFF_DATA, '0, '0);
		issue(OP_READ, OFF_DATA, '0, '0);
		// transmit path, then a pop from the emptied queue
		issue(OP_WRITE, OFF_DATA, 32'h1234_56FF, '0);
		issue(OP_POP, '0, '0, '0);
		issue(OP_POP, OFFSET_W'(1023), 32'hFFFF_FFFF, 8'hFF);

		// random part: queue fill/drain bursts and mixed accesses
		while (sent < DIRECTED_WORDS + RANDOM_WORDS) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					n = $urandom_range(8, 20);
					repeat (n) issue(OP_INJECT, pick_offset(), $urandom(), rnd_byte());
					if ($urandom_range(0, 1) == 1)
						issue(OP_READ, OFF_STATUS, $urandom(), rnd_byte());
					n = $urandom_range(8, 20);
					repeat (n) issue(OP_READ, OFF_DATA, $urandom(), rnd_byte());
				end
				2, 3: begin
					n = $urandom_range(8, 20);
					repeat (n) issue(OP_WRITE, OFF_DATA, $urandom(), rnd_byte());
					n = $urandom_range(8, 20);
					repeat (n) issue(OP_POP, pick_offset(), $urandom(), rnd_byte());
				end
				default: begin
					repeat (8) issue(op_t'($urandom_range(0, 3)), pick_offset(), $urandom(),
						rnd_byte());
				end
			endcase
		end
		req_ch.valid <= 1'b0;

		// wait for outstanding results, then let any strays arrive
		waited = 0;
		do begin
			@(posedge clk);
			waited++;
		end while (pending != 0 && waited < 5000);
		repeat (10) @(posedge clk);

		$display("run covered %0d words in, %0d results out, %0d mismatches",
			words_in, results_out, fail_count);
		$display("rx drops %0d, tx drops %0d, empty data reads %0d, empty pops %0d",
			rx_drops, tx_drops, empty_reads, empty_pops);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
